FILE: rtl/spsr_pkg.sv
// spsr_pkg: shared types and constants for the spectral phase shift rotator
// turn-fraction angle format, cordic arctangent table and item tag
// no dependencies
`default_nettype none

package spsr_pkg;

	// angles are carried as 32-bit fractions of a full turn
	localparam int TURN_BITS    = 32;
	localparam int CORDIC_STEPS = 24;
	localparam int FRAC_BITS    = 30;

	typedef logic signed [TURN_BITS-1:0] turn_t;

	// inverse cordic gain and unity, both q2.30
	localparam turn_t INV_GAIN_Q30 = 32'sh26DD3B6A;
	localparam turn_t ONE_Q30      = 32'sh40000000;

	// atan(2^-i) in 2^32-per-turn units
	localparam turn_t ATAN_TURN [CORDIC_STEPS] = '{
		32'sh20000000, 32'sh12E4051D, 32'sh09FB385B, 32'sh051111D4,
		32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
		32'sh0028BE53, 32'sh00145F2E, 32'sh000A2F98, 32'sh000517CC,
		32'sh00028BE6, 32'sh000145F3, 32'sh0000A2F9, 32'sh0000517C,
		32'sh000028BE, 32'sh0000145F, 32'sh00000A2F, 32'sh00000517,
		32'sh0000028B, 32'sh00000145, 32'sh000000A2, 32'sh00000051
	};

	// quadrant of the angle and zero-residual bypass flag
	typedef struct packed {
		logic [1:0] quad;
		logic       zero;
	} tag_t;

endpackage

`default_nettype wire

FILE: rtl/spsr_phase.sv
// spsr_phase: angle multiply, direction and quadrant split, two stages
// depends on spsr_pkg
`default_nettype none

module spsr_phase
	import spsr_pkg::*;
#(
	parameter int DATA_BITS  = 24,
	parameter int MODE_BITS  = 10,
	parameter int ANGLE_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic signed [MODE_BITS-1:0]  mode_number,
	input  wire logic signed [DATA_BITS-1:0]  coef_real,
	input  wire logic signed [DATA_BITS-1:0]  coef_imag,
	input  wire logic        [ANGLE_BITS-1:0] shift_angle,
	input  wire logic                         direction,
	output logic                              out_valid,
	output turn_t                             out_resid,
	output tag_t                              out_tag,
	output logic signed [DATA_BITS-1:0]       out_real,
	output logic signed [DATA_BITS-1:0]       out_imag
);

	logic signed [MODE_BITS+ANGLE_BITS:0] prod;
	logic        [ANGLE_BITS-1:0]         angle;
	logic        [ANGLE_BITS-1:0]         phase;
	logic        [TURN_BITS-1:0]          turn;

	logic                          valid_s1, valid_s2;
	logic        [ANGLE_BITS-1:0]  phase_s1;
	logic signed [DATA_BITS-1:0]   re_s1, im_s1, re_s2, im_s2;
	turn_t                         resid_s2;
	tag_t                          tag_s2;

	// product modulo one turn, negated for the minus direction
	always_comb begin
		prod  = mode_number * $signed({1'b0, shift_angle});
		angle = prod[ANGLE_BITS-1:0];
		phase = direction ? (~angle + 1'b1) : angle;
	end

	// residual is the low 30 bits read as signed, quadrant rounds up with it
	assign turn = {phase_s1, {(TURN_BITS-ANGLE_BITS){1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		phase_s1 <= phase;
		re_s1    <= coef_real;
		im_s1    <= coef_imag;

		resid_s2    <= {{(TURN_BITS-FRAC_BITS){turn[FRAC_BITS-1]}}, turn[FRAC_BITS-1:0]};
		tag_s2.quad <= turn[TURN_BITS-1:FRAC_BITS] + {1'b0, turn[FRAC_BITS-1]};
		tag_s2.zero <= (turn[FRAC_BITS-1:0] == '0);
		re_s2       <= re_s1;
		im_s2       <= im_s1;
	end

	assign out_valid = valid_s2;
	assign out_resid = resid_s2;
	assign out_tag   = tag_s2;
	assign out_real  = re_s2;
	assign out_imag  = im_s2;

endmodule

`default_nettype wire

FILE: rtl/spsr_cordic.sv
// spsr_cordic: rotation-mode cordic, one micro-rotation per register stage
// depends on spsr_pkg
`default_nettype none

module spsr_cordic
	import spsr_pkg::*;
#(
	parameter int SIDE_BITS = 48
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire turn_t                in_resid,
	input  wire tag_t                 in_tag,
	input  wire logic [SIDE_BITS-1:0] in_side,
	output logic                      out_valid,
	output turn_t                     out_cos,
	output turn_t                     out_sin,
	output tag_t                      out_tag,
	output logic [SIDE_BITS-1:0]      out_side
);

	logic                 valid_s [1:CORDIC_STEPS];
	turn_t                x_s     [1:CORDIC_STEPS];
	turn_t                y_s     [1:CORDIC_STEPS];
	turn_t                z_s     [1:CORDIC_STEPS];
	tag_t                 tag_s   [1:CORDIC_STEPS];
	logic [SIDE_BITS-1:0] side_s  [1:CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic                 v_in;
		turn_t                x_in, y_in, z_in;
		tag_t                 t_in;
		logic [SIDE_BITS-1:0] d_in;

		if (i == 0) begin : g_first
			assign v_in = in_valid;
			assign x_in = INV_GAIN_Q30;
			assign y_in = '0;
			assign z_in = in_resid;
			assign t_in = in_tag;
			assign d_in = in_side;
		end else begin : g_next
			assign v_in = valid_s[i];
			assign x_in = x_s[i];
			assign y_in = y_s[i];
			assign z_in = z_s[i];
			assign t_in = tag_s[i];
			assign d_in = side_s[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else begin
				valid_s[i+1] <= v_in;
			end
		end

		// rotate towards zero residual, both updates from the old x and y
		always_ff @(posedge clk) begin
			if (!z_in[TURN_BITS-1]) begin
				x_s[i+1] <= x_in - (y_in >>> i);
				y_s[i+1] <= y_in + (x_in >>> i);
				z_s[i+1] <= z_in - ATAN_TURN[i];
			end else begin
				x_s[i+1] <= x_in + (y_in >>> i);
				y_s[i+1] <= y_in - (x_in >>> i);
				z_s[i+1] <= z_in + ATAN_TURN[i];
			end
			tag_s[i+1]  <= t_in;
			side_s[i+1] <= d_in;
		end
	end

	assign out_valid = valid_s[CORDIC_STEPS];
	assign out_cos   = x_s[CORDIC_STEPS];
	assign out_sin   = y_s[CORDIC_STEPS];
	assign out_tag   = tag_s[CORDIC_STEPS];
	assign out_side  = side_s[CORDIC_STEPS];

endmodule

`default_nettype wire

FILE: rtl/spsr_cmul.sv
// spsr_cmul: quadrant mapping, complex multiply, rounding and saturation
// four register stages; depends on spsr_pkg
`default_nettype none

module spsr_cmul
	import spsr_pkg::*;
#(
	parameter int DATA_BITS = 24
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire turn_t                       in_cos,
	input  wire turn_t                       in_sin,
	input  wire tag_t                        in_tag,
	input  wire logic signed [DATA_BITS-1:0] in_real,
	input  wire logic signed [DATA_BITS-1:0] in_imag,
	output logic                             out_valid,
	output logic signed [DATA_BITS-1:0]      rot_real,
	output logic signed [DATA_BITS-1:0]      rot_imag
);

	localparam int PROD_BITS = TURN_BITS + DATA_BITS;
	localparam int SUM_BITS  = PROD_BITS + 1;
	localparam int RES_BITS  = SUM_BITS - FRAC_BITS;

	turn_t cr, sr, c_map, s_map;

	logic                         valid_s1, valid_s2, valid_s3, valid_s4;
	turn_t                        c_s1, s_s1;
	logic signed [DATA_BITS-1:0]  re_s1, im_s1;
	logic signed [PROD_BITS-1:0]  cre_s2, sim_s2, cim_s2, sre_s2;
	logic signed [SUM_BITS-1:0]   sum_re, sum_im;
	logic signed [RES_BITS-1:0]   re_s3, im_s3;
	logic signed [DATA_BITS-1:0]  re_s4, im_s4;

	function automatic logic signed [DATA_BITS-1:0] clamp(input logic signed [RES_BITS-1:0] v);
		logic [RES_BITS-DATA_BITS:0] top;
		top = v[RES_BITS-1:DATA_BITS-1];
		if (top == '0 || top == '1) begin
			clamp = v[DATA_BITS-1:0];
		end else if (v[RES_BITS-1]) begin
			clamp = {1'b1, {(DATA_BITS-1){1'b0}}};
		end else begin
			clamp = {1'b0, {(DATA_BITS-1){1'b1}}};
		end
	endfunction

	// zero residual takes the exact unit vector
	always_comb begin
		cr = in_tag.zero ? ONE_Q30 : in_cos;
		sr = in_tag.zero ? turn_t'(0) : in_sin;
		case (in_tag.quad)
			2'd0: begin
				c_map = cr;
				s_map = sr;
			end
			2'd1: begin
				c_map = -sr;
				s_map = cr;
			end
			2'd2: begin
				c_map = -cr;
				s_map = -sr;
			end
			default: begin
				c_map = sr;
				s_map = -cr;
			end
		endcase
	end

	always_comb begin
		sum_re = SUM_BITS'(cre_s2) + SUM_BITS'(sim_s2) + (SUM_BITS'(1) <<< (FRAC_BITS - 1));
		sum_im = SUM_BITS'(cim_s2) - SUM_BITS'(sre_s2) + (SUM_BITS'(1) <<< (FRAC_BITS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		c_s1  <= c_map;
		s_s1  <= s_map;
		re_s1 <= in_real;
		im_s1 <= in_imag;

		cre_s2 <= c_s1 * re_s1;
		sim_s2 <= s_s1 * im_s1;
		cim_s2 <= c_s1 * im_s1;
		sre_s2 <= s_s1 * re_s1;

		re_s3 <= sum_re[SUM_BITS-1:FRAC_BITS];
		im_s3 <= sum_im[SUM_BITS-1:FRAC_BITS];

		re_s4 <= clamp(re_s3);
		im_s4 <= clamp(im_s3);
	end

	assign out_valid = valid_s4;
	assign rot_real  = re_s4;
	assign rot_imag  = im_s4;

endmodule

`default_nettype wire

FILE: rtl/spectral_phase_shift_rotator.sv
// spectral_phase_shift_rotator: top level, config registers and pipeline
// depends on spsr_pkg, spsr_phase, spsr_cordic, spsr_cmul
`default_nettype none

//  channel   signals                                   direction  handshake
//  input     start, busy, mode_number, coef_real/imag  in         start & !busy
//  result    done, rot_real, rot_imag                  out        done, one cycle
//  config    psel, penable, pwrite, paddr, pwdata,     in/out     apb, pready high
//            prdata, pready
//
// one item enters every cycle; each result passes through the pipeline stages
// (two phase stages, one per cordic micro-rotation, four multiply stages)
// busy is never raised: the pipeline never stalls and the receiver cannot stall
// reset clears only the valid bits and the registers; payload is not reset

module spectral_phase_shift_rotator
	import spsr_pkg::*;
#(
	parameter int DATA_BITS  = 24,
	parameter int MODE_BITS  = 10,
	parameter int ANGLE_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// item in
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic signed [MODE_BITS-1:0] mode_number,
	input  wire logic signed [DATA_BITS-1:0] coef_real,
	input  wire logic signed [DATA_BITS-1:0] coef_imag,
	// item out
	output logic                             done,
	output logic signed [DATA_BITS-1:0]      rot_real,
	output logic signed [DATA_BITS-1:0]      rot_imag,
	// register port
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [2:0]                  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	localparam int LATENCY = 2 + CORDIC_STEPS + 4;

	// register index from the word address
	localparam logic REG_SHIFT_ANGLE = 1'b0;
	localparam logic REG_DIRECTION   = 1'b1;

	logic [ANGLE_BITS-1:0] shift_angle_q;
	logic                  direction_q;
	logic                  wr_en;
	logic                  accept;

	// phase stage to cordic
	logic                        ph_valid;
	turn_t                       ph_resid;
	tag_t                        ph_tag;
	logic signed [DATA_BITS-1:0] ph_real, ph_imag;

	// cordic to multiplier, coefficient travels as side-band
	logic                   cd_valid;
	turn_t                  cd_cos, cd_sin;
	tag_t                   cd_tag;
	logic [2*DATA_BITS-1:0] cd_side;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign accept = start & ~busy;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_angle_q <= '0;
			direction_q   <= 1'b0;
		end else if (wr_en) begin
			case (paddr[2])
				REG_SHIFT_ANGLE: shift_angle_q <= pwdata[ANGLE_BITS-1:0];
				REG_DIRECTION:   direction_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_SHIFT_ANGLE: prdata = {{(32-ANGLE_BITS){1'b0}}, shift_angle_q};
			REG_DIRECTION:   prdata = {31'b0, direction_q};
			default:         prdata = '0;
		endcase
	end

	// angle multiply and quadrant split
	spsr_phase #(
		.DATA_BITS  (DATA_BITS),
		.MODE_BITS  (MODE_BITS),
		.ANGLE_BITS (ANGLE_BITS)
	) u_phase (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (accept),
		.mode_number (mode_number),
		.coef_real   (coef_real),
		.coef_imag   (coef_imag),
		.shift_angle (shift_angle_q),
		.direction   (direction_q),
		.out_valid   (ph_valid),
		.out_resid   (ph_resid),
		.out_tag     (ph_tag),
		.out_real    (ph_real),
		.out_imag    (ph_imag)
	);

	// cosine and sine of the residual within plus or minus an eighth turn
	spsr_cordic #(
		.SIDE_BITS (2*DATA_BITS)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ph_valid),
		.in_resid  (ph_resid),
		.in_tag    (ph_tag),
		.in_side   ({ph_real, ph_imag}),
		.out_valid (cd_valid),
		.out_cos   (cd_cos),
		.out_sin   (cd_sin),
		.out_tag   (cd_tag),
		.out_side  (cd_side)
	);

	// rotation of the coefficient, rounding and clamping
	spsr_cmul #(
		.DATA_BITS (DATA_BITS)
	) u_cmul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cd_valid),
		.in_cos    (cd_cos),
		.in_sin    (cd_sin),
		.in_tag    (cd_tag),
		.in_real   (cd_side[2*DATA_BITS-1:DATA_BITS]),
		.in_imag   (cd_side[DATA_BITS-1:0]),
		.out_valid (done),
		.rot_real  (rot_real),
		.rot_imag  (rot_imag)
	);

	// every accepted item gives a result after the fixed latency
	a_item_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("accepted item gave no result");

	// no result without an item accepted that far back
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |-> ##LATENCY !done)
		else $error("result without an accepted item");

	// mode zero passes the coefficient through unchanged
	a_mode_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode_number == '0) |-> ##LATENCY
		(rot_real == $past(coef_real, LATENCY) && rot_imag == $past(coef_imag, LATENCY)))
		else $error("mode zero item was altered");

endmodule

`default_nettype wire
